// ----- rtl/core/heavy_flow_bucket_sketch_top_defines.svh -----
// Assertion macros for the bucket sketch.
// Define NO_ASSERTIONS to compile the checks out.
`ifndef HEAVY_FLOW_BUCKET_SKETCH_TOP_DEFINES_SVH
`define HEAVY_FLOW_BUCKET_SKETCH_TOP_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define HFBS_ASSERT_IMPLY(label, clk, rst_n, a, b, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) else $error(msg);
`define HFBS_ASSERT_NEXT(label, clk, rst_n, a, b, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) else $error(msg);
`else
`define HFBS_ASSERT_IMPLY(label, clk, rst_n, a, b, msg)
`define HFBS_ASSERT_NEXT(label, clk, rst_n, a, b, msg)
`endif
`endif

// ----- rtl/core/hfbs_pkg.sv -----
// Shared types, constants and saturation helpers for the bucket sketch.
// No dependencies.
`timescale 1ns / 1ps
package hfbs_pkg;
  localparam int BKT_MAX_W = 16;
  localparam logic [31:0] MIX_K1 = 32'h85ebca6b;
  localparam logic [31:0] MIX_K2 = 32'hc2b2ae35;
  localparam logic [30:0] CNT_MAX = 31'h7FFFFFFF;

  typedef struct packed {
    logic                 func;
    logic [30:0]          fp;
    logic [BKT_MAX_W-1:0] bkt;
  } item_t;

  typedef enum logic [1:0] {FR_IDLE, FR_RUN, FR_PUSH} front_state_t;
  typedef enum logic [2:0] {BK_CLEAR, BK_IDLE, BK_READ, BK_SCAN, BK_DECIDE, BK_WRITE}
    back_state_t;

  // Clamp a 34-bit signed sum to the signed 32-bit range.
  function automatic logic [31:0] sat32(input logic signed [33:0] v);
    logic [31:0] r;
    if (v > 34'sh07FFFFFFF) r = 32'h7FFFFFFF;
    else if (v < -34'sh080000000) r = 32'h80000000;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic [30:0] inc_cnt(input logic [30:0] c);
    return (c == CNT_MAX) ? CNT_MAX : c + 31'd1;
  endfunction
endpackage

// ----- rtl/core/heavy_flow_bucket_sketch_top.sv -----
// Bucket sketch top level: front end, queue and back end.
// Front: takes an item, runs the finaliser and the reciprocal remainder in FR_RUN, then pushes
// it in FR_PUSH; it takes no new item until the push is done. Back: reads the bucket, scans one
// slot per cycle, decides and writes back, which sets the throughput; it pops no new item until
// the result is loaded, so a low out_ready stalls it. After reset a clearing pass zeroes the
// bucket memory; no item is taken meanwhile.
`timescale 1ns / 1ps
`include "heavy_flow_bucket_sketch_top_defines.svh"
module heavy_flow_bucket_sketch_top #(
  parameter int NUM_BUCKETS      = 256,
  parameter int SLOTS_PER_BUCKET = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_func,
  input  logic [30:0] in_flow_hash,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_found,
  output logic [30:0] out_count
);
  logic            push, full, pop, empty, clearing;
  hfbs_pkg::item_t push_item, head;

  hfbs_front #(.NUM_BUCKETS(NUM_BUCKETS)) u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_func, .in_flow_hash,
    .hold(clearing), .push, .full, .push_item
  );

  hfbs_queue u_queue (
    .clk, .rst_n, .push, .push_item, .full, .pop, .empty, .head
  );

  hfbs_back #(.NUM_BUCKETS(NUM_BUCKETS), .SLOTS_PER_BUCKET(SLOTS_PER_BUCKET)) u_back (
    .clk, .rst_n, .empty, .head, .pop, .clearing,
    .out_valid, .out_ready, .out_found, .out_count
  );

  `HFBS_ASSERT_IMPLY(a_no_push_full, clk, rst_n, push, !full, "push into a full queue")
  `HFBS_ASSERT_IMPLY(a_no_pop_empty, clk, rst_n, pop, !empty, "pop from an empty queue")
  `HFBS_ASSERT_IMPLY(a_count_found, clk, rst_n, out_valid && !out_found, out_count == 31'd0,
                     "count without a match")
  `HFBS_ASSERT_NEXT(a_clear_no_pop, clk, rst_n, clearing, !in_ready || !clearing,
                    "item taken during clearing pass")
endmodule

// ----- rtl/core/hfbs_front.sv -----
// Front end: takes an item, forms the fingerprint and the bucket index.
// Uses hfbs_pkg; the bucket index is reduced from a registered reciprocal product.
`timescale 1ns / 1ps
module hfbs_front #(
  parameter int NUM_BUCKETS = 256
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_func,
  input  logic [30:0]         in_flow_hash,
  input  logic                hold,
  output logic                push,
  input  logic                full,
  output hfbs_pkg::item_t     push_item
);
  // The reciprocal is rounded up by less than NUM_BUCKETS parts in 2^RCP_SH, so the
  // quotient is exact for every 31-bit hash.
  localparam int          RCP_SH = 31 + $clog2(NUM_BUCKETS);
  localparam logic [63:0] RCP_W  = ((64'd1 << RCP_SH) + 64'(NUM_BUCKETS) - 64'd1) /
                                   64'(NUM_BUCKETS);
  localparam logic [31:0] RCP    = RCP_W[31:0];
  localparam logic [30:0] NB_31  = 31'(NUM_BUCKETS);

  hfbs_pkg::front_state_t state_r, state_nxt;
  logic [30:0]  hash_r;
  logic         func_r;
  logic [31:0]  x_r;
  logic [62:0]  prod_r;
  logic [30:0]  quo;
  logic [hfbs_pkg::BKT_MAX_W-1:0] rem_r;
  logic [1:0]   step_r;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= hfbs_pkg::FR_IDLE;
    else state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    push      = 1'b0;
    unique case (state_r)
      hfbs_pkg::FR_IDLE: begin
        in_ready = !hold;
        if (in_valid && !hold) state_nxt = hfbs_pkg::FR_RUN;
      end
      hfbs_pkg::FR_RUN: begin
        if (step_r == 2'd0) state_nxt = hfbs_pkg::FR_PUSH;
      end
      hfbs_pkg::FR_PUSH: begin
        push = !full;
        if (!full) state_nxt = hfbs_pkg::FR_IDLE;
      end
      default: state_nxt = hfbs_pkg::FR_IDLE;
    endcase
  end

  assign quo = 31'(prod_r >> RCP_SH);

  always_ff @(posedge clk) begin
    if (state_r == hfbs_pkg::FR_IDLE && in_valid && !hold) begin
      hash_r <= in_flow_hash;
      func_r <= in_func;
      x_r    <= {1'b0, in_flow_hash} ^ ({1'b0, in_flow_hash} >> 16);
      step_r <= 2'd2;
    end else if (state_r == hfbs_pkg::FR_RUN) begin
      step_r <= step_r - 2'd1;
      // The finaliser and the remainder share the run steps.
      if (step_r == 2'd2) begin
        x_r    <= 32'(x_r * hfbs_pkg::MIX_K1);
        prod_r <= 63'(hash_r) * 63'(RCP);
      end else if (step_r == 2'd1) begin
        x_r   <= 32'((x_r ^ (x_r >> 13)) * hfbs_pkg::MIX_K2);
        rem_r <= hfbs_pkg::BKT_MAX_W'(hash_r - quo * NB_31);
      end else begin
        x_r <= x_r ^ (x_r >> 16);
      end
    end
  end

  assign push_item.func = func_r;
  assign push_item.fp   = x_r[30:0];
  assign push_item.bkt  = rem_r;
endmodule

// ----- rtl/core/hfbs_queue.sv -----
// Two-entry queue between the front and back ends.
// Uses hfbs_pkg for the item type.
`timescale 1ns / 1ps
module hfbs_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  hfbs_pkg::item_t push_item,
  output logic            full,
  input  logic            pop,
  output logic            empty,
  output hfbs_pkg::item_t head
);
  hfbs_pkg::item_t mem_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (pop) rd_ptr_r <= !rd_ptr_r;
      if (push && !pop) cnt_r <= cnt_r + 2'd1;
      else if (pop && !push) cnt_r <= cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_item;
  end

  assign full  = (cnt_r == 2'd2);
  assign empty = (cnt_r == 2'd0);
  assign head  = mem_r[rd_ptr_r];
endmodule

// ----- rtl/core/hfbs_back.sv -----
// Back end: bucket memory, clearing pass, slot scan, update and result register.
// Uses hfbs_pkg for types and saturation helpers.
`timescale 1ns / 1ps
module hfbs_back #(
  parameter int NUM_BUCKETS      = 256,
  parameter int SLOTS_PER_BUCKET = 16
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            empty,
  input  hfbs_pkg::item_t head,
  output logic            pop,
  output logic            clearing,
  output logic            out_valid,
  input  logic            out_ready,
  output logic            out_found,
  output logic [30:0]     out_count
);
  localparam int BKT_W  = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
  localparam int SL_W   = (SLOTS_PER_BUCKET > 1) ? $clog2(SLOTS_PER_BUCKET) : 1;
  localparam int SLOT_W = 63;
  localparam int ROW_W  = SLOTS_PER_BUCKET * SLOT_W + 32;

  hfbs_pkg::back_state_t state_r, state_nxt;

  logic [ROW_W-1:0] mem [NUM_BUCKETS];
  logic [ROW_W-1:0] rd_data_r;
  logic [ROW_W-1:0] wr_data;
  logic             mem_we;
  logic [BKT_W-1:0] wr_addr;
  logic [BKT_W-1:0] clr_r;

  logic             func_r;
  logic [30:0]      fp_in_r;
  logic [BKT_W-1:0] bkt_r;
  logic [30:0]      fp_r   [SLOTS_PER_BUCKET];
  logic [30:0]      cnt_r  [SLOTS_PER_BUCKET];
  logic             real_r [SLOTS_PER_BUCKET];
  logic [31:0]      inc_r;
  logic [SL_W-1:0]  sidx_r;
  logic             match_v_r, empty_v_r, add_sign_r;
  logic [SL_W-1:0]  match_idx_r, empty_idx_r, minpos_r;
  logic [30:0]      minval_r;
  logic             found_r;
  logic [30:0]      count_r;
  logic             out_load;

  logic signed [32:0] sinc;
  logic signed [33:0] old_add;
  logic [31:0]        inc_fin;
  logic [SL_W-1:0]    tgt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= hfbs_pkg::BK_CLEAR;
    else state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    pop       = 1'b0;
    out_load  = 1'b0;
    clearing  = 1'b0;
    unique case (state_r)
      hfbs_pkg::BK_CLEAR: begin
        clearing = 1'b1;
        if (clr_r == BKT_W'(NUM_BUCKETS - 1)) state_nxt = hfbs_pkg::BK_IDLE;
      end
      hfbs_pkg::BK_IDLE: begin
        pop = !empty;
        if (!empty) state_nxt = hfbs_pkg::BK_READ;
      end
      hfbs_pkg::BK_READ: state_nxt = hfbs_pkg::BK_SCAN;
      hfbs_pkg::BK_SCAN: begin
        if (sidx_r == SL_W'(SLOTS_PER_BUCKET - 1)) state_nxt = hfbs_pkg::BK_DECIDE;
      end
      hfbs_pkg::BK_DECIDE: state_nxt = hfbs_pkg::BK_WRITE;
      hfbs_pkg::BK_WRITE: begin
        out_load = !out_valid || out_ready;
        if (out_load) state_nxt = hfbs_pkg::BK_IDLE;
      end
      default: state_nxt = hfbs_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) clr_r <= '0;
    else if (state_r == hfbs_pkg::BK_CLEAR) clr_r <= clr_r + BKT_W'(1);
  end

  // Final incast step of the match and full cases.
  always_comb begin
    if (add_sign_r)
      inc_fin = hfbs_pkg::sat32({{2{inc_r[31]}}, inc_r} + (fp_in_r[0] ? -34'sd1 : 34'sd1));
    else
      inc_fin = inc_r;
  end

  always_comb begin
    for (int i = 0; i < SLOTS_PER_BUCKET; i++)
      wr_data[i*SLOT_W +: SLOT_W] = {real_r[i], cnt_r[i], fp_r[i]};
    wr_data[SLOTS_PER_BUCKET*SLOT_W +: 32] = inc_fin;
    if (state_r == hfbs_pkg::BK_CLEAR) begin
      mem_we  = 1'b1;
      wr_addr = clr_r;
      wr_data = '0;
    end else begin
      mem_we  = out_load && func_r;
      wr_addr = bkt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[wr_addr] <= wr_data;
    rd_data_r <= mem[BKT_W'(head.bkt)];
  end

  always_comb begin
    sinc    = fp_in_r[0] ? -$signed({inc_r[31], inc_r}) : $signed({inc_r[31], inc_r});
    old_add = $signed({{2{inc_r[31]}}, inc_r}) +
              (fp_r[minpos_r][0] ? -$signed({3'b000, cnt_r[minpos_r]})
                                 : $signed({3'b000, cnt_r[minpos_r]}));
    if (empty_v_r && (!match_v_r || empty_idx_r < match_idx_r)) tgt = empty_idx_r;
    else if (match_v_r) tgt = match_idx_r;
    else tgt = minpos_r;
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      hfbs_pkg::BK_IDLE: begin
        func_r  <= head.func;
        fp_in_r <= head.fp;
        bkt_r   <= BKT_W'(head.bkt);
      end
      hfbs_pkg::BK_READ: begin
        for (int i = 0; i < SLOTS_PER_BUCKET; i++) begin
          fp_r[i]   <= rd_data_r[i*SLOT_W +: 31];
          cnt_r[i]  <= rd_data_r[i*SLOT_W + 31 +: 31];
          real_r[i] <= rd_data_r[i*SLOT_W + 62];
        end
        inc_r      <= rd_data_r[SLOTS_PER_BUCKET*SLOT_W +: 32];
        sidx_r     <= '0;
        match_v_r  <= 1'b0;
        empty_v_r  <= 1'b0;
        minval_r   <= '0;
        minpos_r   <= '0;
        add_sign_r <= 1'b0;
      end
      hfbs_pkg::BK_SCAN: begin
        if (cnt_r[sidx_r] == 31'd0) begin
          if (!empty_v_r) begin
            empty_v_r   <= 1'b1;
            empty_idx_r <= sidx_r;
          end
        end else begin
          if (!match_v_r && fp_r[sidx_r] == fp_in_r) begin
            match_v_r   <= 1'b1;
            match_idx_r <= sidx_r;
          end
          if (minval_r == 31'd0 || cnt_r[sidx_r] < minval_r) begin
            minval_r <= cnt_r[sidx_r];
            minpos_r <= sidx_r;
          end
        end
        sidx_r <= sidx_r + SL_W'(1);
      end
      hfbs_pkg::BK_DECIDE: begin
        found_r <= match_v_r;
        count_r <= match_v_r ? cnt_r[match_idx_r] : 31'd0;
        if (empty_v_r && (!match_v_r || empty_idx_r < match_idx_r)) begin
          fp_r[tgt]   <= fp_in_r;
          cnt_r[tgt]  <= 31'd1;
          real_r[tgt] <= 1'b1;
        end else if (match_v_r) begin
          cnt_r[tgt] <= hfbs_pkg::inc_cnt(cnt_r[tgt]);
          add_sign_r <= !real_r[tgt];
        end else begin
          add_sign_r <= 1'b1;
          // A full bucket gives up its weakest slot once incast reaches or outweighs it.
          if (sinc >= $signed({2'b00, minval_r})) begin
            if (real_r[tgt]) inc_r <= hfbs_pkg::sat32(old_add);
            fp_r[tgt]   <= fp_in_r;
            cnt_r[tgt]  <= hfbs_pkg::inc_cnt(cnt_r[tgt]);
            real_r[tgt] <= 1'b0;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid <= 1'b0;
    else if (out_load) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_found <= found_r;
      out_count <= count_r;
    end
  end
endmodule
